// File: design/cfp_pkg.sv
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types and constants of the checksum frame parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

    localparam logic [7:0] START_BYTE      = 8'h68;
    localparam logic [7:0] END_BYTE        = 8'h16;
    localparam logic [7:0] PAYLOAD_BIAS    = 8'h33;
    localparam logic [7:0] MAX_PAYLOAD_RST = 8'hFF;
    localparam logic [8:0] HEADER_LEN      = 9'd5;

    localparam logic [8:0] POS_ADDRESS   = 9'd1;
    localparam logic [8:0] POS_INV_ADDR  = 9'd2;
    localparam logic [8:0] POS_START2    = 9'd3;
    localparam logic [8:0] POS_OPERATION = 9'd4;

    typedef enum logic [2:0] {
        PH_HUNT     = 3'd0,
        PH_HEADER   = 3'd1,
        PH_PAYLOAD  = 3'd2,
        PH_CHECKSUM = 3'd3,
        PH_END      = 3'd4,
        PH_SKIP     = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TRUNC    = 3'd1,
        ST_BAD_SUM  = 3'd2,
        ST_BAD_END  = 3'd3,
        ST_BAD_HDR  = 3'd4,
        ST_TOO_LONG = 3'd5
    } t_status;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] frame_address;
        logic [7:0] frame_operation;
        logic [7:0] frame_payload_length;
        logic [2:0] status;
    } t_result;

endpackage

// File: design/cfp_in_if.sv
// ----------------------------------------------------------------------------
// cfp_in_if
// Received byte channel: valid/ready handshake with byte and buffer-end flag.
// ----------------------------------------------------------------------------
interface cfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       buffer_end;

    modport source (output valid, output rx_byte, output buffer_end, input ready);
    modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

// File: design/cfp_out_if.sv
// ----------------------------------------------------------------------------
// cfp_out_if
// Result channel: decoded payload bytes and frame status reports.
// ----------------------------------------------------------------------------
interface cfp_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_address;
    logic [7:0] frame_operation;
    logic [7:0] frame_payload_length;
    logic [2:0] status;

    modport source (output valid, output kind, output payload_byte, output payload_index,
                    output frame_address, output frame_operation,
                    output frame_payload_length, output status, input ready);
    modport sink   (input valid, input kind, input payload_byte, input payload_index,
                    input frame_address, input frame_operation,
                    input frame_payload_length, input status, output ready);
endinterface

// File: design/cfp_parser.sv
// ----------------------------------------------------------------------------
// cfp_parser
// Frame state machine: tracks phase, header fields and running checksum,
// and forms at most one result per accepted byte.
// ----------------------------------------------------------------------------
module cfp_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_accept,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_buffer_end,
    output logic             o_res_valid,
    output cfp_pkg::t_result o_res
);
    import cfp_pkg::*;

    t_phase     r_phase,     n_phase;
    logic [8:0] r_pos,       n_pos;
    logic [7:0] r_address,   n_address;
    logic       r_hdr_ok,    n_hdr_ok;
    logic [7:0] r_operation, n_operation;
    logic [7:0] r_length,    n_length;
    logic [7:0] r_sum,       n_sum;
    logic       r_sum_ok,    n_sum_ok;
    logic [7:0] r_max_payload;

    logic [7:0] pay_idx;
    t_status    status;
    logic       emit;
    logic       emit_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (i_cfg_we) begin
            r_max_payload <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_pos       <= '0;
            r_address   <= '0;
            r_hdr_ok    <= 1'b1;
            r_operation <= '0;
            r_length    <= '0;
            r_sum       <= '0;
            r_sum_ok    <= 1'b0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_address   <= n_address;
            r_hdr_ok    <= n_hdr_ok;
            r_operation <= n_operation;
            r_length    <= n_length;
            r_sum       <= n_sum;
            r_sum_ok    <= n_sum_ok;
        end
    end

    assign pay_idx = r_pos[7:0] - 8'(HEADER_LEN + 9'd1);

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_address   = r_address;
        n_hdr_ok    = r_hdr_ok;
        n_operation = r_operation;
        n_length    = r_length;
        n_sum       = r_sum;
        n_sum_ok    = r_sum_ok;
        emit        = 1'b0;
        emit_kind   = KIND_STATUS;
        status      = ST_OK;

        case (r_phase)
            PH_HUNT, PH_SKIP: begin
                if (r_phase == PH_HUNT && i_rx_byte == START_BYTE) begin
                    n_address   = '0;
                    n_operation = '0;
                    n_length    = '0;
                    n_hdr_ok    = 1'b1;
                    n_sum_ok    = 1'b0;
                    n_sum       = START_BYTE;
                    n_pos       = 9'd1;
                    n_phase     = PH_HEADER;
                    if (i_buffer_end) begin
                        n_phase = PH_HUNT;
                        emit    = 1'b1;
                        status  = ST_TRUNC;
                    end
                end else if (i_buffer_end) begin
                    n_phase = PH_HUNT;
                end
            end
            PH_END: begin
                // first failing check wins
                if (!r_sum_ok) begin
                    status = ST_BAD_SUM;
                end else if (i_rx_byte != END_BYTE) begin
                    status = ST_BAD_END;
                end else if (!r_hdr_ok) begin
                    status = ST_BAD_HDR;
                end else if (r_length > r_max_payload) begin
                    status = ST_TOO_LONG;
                end
                emit    = 1'b1;
                n_phase = i_buffer_end ? PH_HUNT : PH_SKIP;
            end
            default: begin
                if (i_buffer_end) begin
                    // buffer ended inside the frame
                    n_phase = PH_HUNT;
                    emit    = 1'b1;
                    status  = ST_TRUNC;
                end else begin
                    case (r_phase)
                        PH_HEADER: begin
                            n_sum = r_sum + i_rx_byte;
                            case (r_pos)
                                POS_ADDRESS:   n_address = i_rx_byte;
                                POS_INV_ADDR:  if (i_rx_byte != ~r_address) n_hdr_ok = 1'b0;
                                POS_START2:    if (i_rx_byte != START_BYTE) n_hdr_ok = 1'b0;
                                POS_OPERATION: n_operation = i_rx_byte;
                                default:       n_length = i_rx_byte;
                            endcase
                            if (r_pos >= HEADER_LEN) begin
                                n_phase = (n_length == '0) ? PH_CHECKSUM : PH_PAYLOAD;
                            end
                            n_pos = r_pos + 9'd1;
                        end
                        PH_PAYLOAD: begin
                            n_sum     = r_sum + i_rx_byte;
                            emit      = 1'b1;
                            emit_kind = KIND_PAYLOAD;
                            if ({1'b0, pay_idx} + 9'd1 >= {1'b0, r_length}) begin
                                n_phase = PH_CHECKSUM;
                            end
                            n_pos = r_pos + 9'd1;
                        end
                        default: begin
                            // checksum byte
                            n_sum_ok = (i_rx_byte == r_sum);
                            n_pos    = r_pos + 9'd1;
                            n_phase  = PH_END;
                        end
                    endcase
                end
            end
        endcase
    end

    always_comb begin
        o_res_valid                = emit;
        o_res.kind                 = emit_kind;
        o_res.payload_byte         = (emit_kind == KIND_PAYLOAD) ? i_rx_byte - PAYLOAD_BIAS : '0;
        o_res.payload_index        = (emit_kind == KIND_PAYLOAD) ? pay_idx : '0;
        o_res.frame_address        = n_address;
        o_res.frame_operation      = n_operation;
        o_res.frame_payload_length = n_length;
        o_res.status               = status;
    end

endmodule

// File: design/cfp_out_stage.sv
// ----------------------------------------------------------------------------
// cfp_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module cfp_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load_req,
    input  logic             i_res_valid,
    input  cfp_pkg::t_result i_res,
    output logic             o_can_load,
    cfp_out_if.source        o_out
);
    import cfp_pkg::*;

    logic    r_valid;
    t_result r_res;

    // free when empty or when the held result leaves this cycle
    assign o_can_load = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load_req && i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load_req && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid                = r_valid;
    assign o_out.kind                 = r_res.kind;
    assign o_out.payload_byte         = r_res.payload_byte;
    assign o_out.payload_index        = r_res.payload_index;
    assign o_out.frame_address        = r_res.frame_address;
    assign o_out.frame_operation      = r_res.frame_operation;
    assign o_out.frame_payload_length = r_res.frame_payload_length;
    assign o_out.status               = r_res.status;

endmodule

// File: design/checksum_frame_parser_core.sv
// ----------------------------------------------------------------------------
// checksum_frame_parser_core
// Byte-serial parser for 0x68-framed, checksummed meter link frames.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one received byte per transaction plus a buffer-end flag.
//   o_out carries results: a payload byte with 0x33 removed and its index,
//   or a frame status report (ok, truncated, bad checksum, bad end byte,
//   bad header, payload too long) with the address, operation and length.
//   A byte causes at most one result transaction.
//   Throughput: one byte per cycle while the output register can load. The
//   frame state machine updates in the accepting cycle; its result is loaded
//   into the output register at the end of that cycle.
//   i_in.ready is high while the output register is empty or is being
//   drained; a stalled receiver holds the result and stalls the input only
//   once that register is full.
//   i_cfg_we / i_cfg_data write the payload length limit (reset 255).
//   Reset (synchronous, active low) returns to hunting for a start byte and
//   empties the output register.
// ----------------------------------------------------------------------------
module checksum_frame_parser_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    cfp_in_if.sink     i_in,
    cfp_out_if.source  o_out
);
    import cfp_pkg::*;

    logic    can_load;
    logic    accept;
    logic    res_valid;
    t_result res;

    assign i_in.ready = can_load;
    assign accept     = i_in.valid && can_load;

    cfp_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_rx_byte    (i_in.rx_byte),
        .i_buffer_end (i_in.buffer_end),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    cfp_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load_req  (accept),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_can_load  (can_load),
        .o_out       (o_out)
    );

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for checksum_frame_parser_core. A short table of hand-written
// bytes runs first. Random frames follow, most of them well formed and some
// with a broken header, checksum or end byte, a buffer cut mid-frame, noise
// or trailing bytes. Each accepted byte updates a behavioral parser, and
// every result transaction is compared field by field with what that parser
// expects. Both handshakes idle at random except in the last phase. The
// payload limit is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
    import cfp_pkg::*;

    localparam int ITEMS        = 900;
    localparam int PHASES       = 4;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct packed {
        logic [7:0] rx;
        logic       last;
        logic       typed;    // exp holds a hand-written result
        t_result    exp;
    } t_row;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_data;
    logic       stall_en = 1'b0;
    int         errors = 0;
    int         cycles = 0;
    int         sent = 0;

    // behavioral parser state
    t_phase     parse_phase;
    logic [8:0] byte_pos;
    logic [7:0] frame_addr;
    logic [7:0] frame_op;
    logic [7:0] frame_len;
    logic [7:0] sum_acc;
    logic [7:0] len_limit;
    logic       hdr_good;
    logic       sum_good;
    t_result    decoded_q[$];

    cfp_in_if  rx_if();
    cfp_out_if res_if();

    checksum_frame_parser_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (rx_if),
        .o_out      (res_if)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_result mk_res(logic kind, logic [7:0] pb, logic [7:0] pi,
                                       logic [7:0] addr, logic [7:0] op,
                                       logic [7:0] len, t_status st);
        t_result r;
        r.kind                 = kind;
        r.payload_byte         = pb;
        r.payload_index        = pi;
        r.frame_address        = addr;
        r.frame_operation      = op;
        r.frame_payload_length = len;
        r.status               = st;
        return r;
    endfunction

    function automatic t_result form_result(logic kind, logic [7:0] pb, logic [7:0] pi,
                                            t_status st);
        return mk_res(kind, pb, pi, frame_addr, frame_op, frame_len, st);
    endfunction

    // Advances the parser by one byte; returns 1 when the byte yields a result.
    function automatic logic parse_byte(input logic [7:0] b, input logic last,
                                        output t_result r);
        logic [7:0] idx;
        t_status    st;
        r = '0;
        if (parse_phase == PH_HUNT || parse_phase == PH_SKIP) begin
            if (parse_phase == PH_HUNT && b == START_BYTE) begin
                frame_addr = 8'h00;
                frame_op   = 8'h00;
                frame_len  = 8'h00;
                hdr_good   = 1'b1;
                sum_good   = 1'b0;
                sum_acc    = START_BYTE;
                byte_pos   = 9'd1;
                if (last) begin
                    r = form_result(KIND_STATUS, 8'h00, 8'h00, ST_TRUNC);
                    return 1'b1;
                end
                parse_phase = PH_HEADER;
                return 1'b0;
            end
            if (last)
                parse_phase = PH_HUNT;
            return 1'b0;
        end
        if (parse_phase == PH_END) begin
            if (!sum_good)
                st = ST_BAD_SUM;
            else if (b != END_BYTE)
                st = ST_BAD_END;
            else if (!hdr_good)
                st = ST_BAD_HDR;
            else if (frame_len > len_limit)
                st = ST_TOO_LONG;
            else
                st = ST_OK;
            parse_phase = last ? PH_HUNT : PH_SKIP;
            r = form_result(KIND_STATUS, 8'h00, 8'h00, st);
            return 1'b1;
        end
        // buffer cut on any frame byte but the end byte
        if (last) begin
            parse_phase = PH_HUNT;
            r = form_result(KIND_STATUS, 8'h00, 8'h00, ST_TRUNC);
            return 1'b1;
        end
        if (parse_phase == PH_HEADER) begin
            sum_acc = sum_acc + b;
            case (byte_pos)
                POS_ADDRESS:   frame_addr = b;
                POS_INV_ADDR:  if (b != ~frame_addr) hdr_good = 1'b0;
                POS_START2:    if (b != START_BYTE) hdr_good = 1'b0;
                POS_OPERATION: frame_op = b;
                default:       frame_len = b;
            endcase
            if (byte_pos >= HEADER_LEN) begin
                if (frame_len == 8'h00)
                    parse_phase = PH_CHECKSUM;
                else
                    parse_phase = PH_PAYLOAD;
            end
            byte_pos = byte_pos + 9'd1;
            return 1'b0;
        end
        if (parse_phase == PH_PAYLOAD) begin
            idx     = 8'(byte_pos - (HEADER_LEN + 9'd1));
            sum_acc = sum_acc + b;
            r = form_result(KIND_PAYLOAD, 8'(b - PAYLOAD_BIAS), idx, ST_OK);
            if ({1'b0, idx} + 9'd1 >= {1'b0, frame_len})
                parse_phase = PH_CHECKSUM;
            byte_pos = byte_pos + 9'd1;
            return 1'b1;
        end
        // checksum byte
        sum_good    = (b == sum_acc);
        byte_pos    = byte_pos + 9'd1;
        parse_phase = PH_END;
        return 1'b0;
    endfunction

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report($sformatf("%s got %02h expected %02h", name, got, want));
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                             input t_result exp);
        t_result r;
        logic    has;
        if (stall_en && $urandom_range(0, 4) == 0) begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        rx_if.valid      <= 1'b1;
        rx_if.rx_byte    <= b;
        rx_if.buffer_end <= last;
        @(posedge clk);
        while (!rx_if.ready) @(posedge clk);
        has = parse_byte(b, last, r);
        if (has)
            decoded_q.push_back(typed ? exp : r);
        sent++;
    endtask

    // Waits for every expected result, then lets the pipeline settle.
    task automatic flush();
        rx_if.valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_limit(input logic [7:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        len_limit = v;
        cfg_we   <= 1'b0;
    endtask

    task automatic send_frame();
        logic [7:0] frm[$];
        logic [7:0] addr;
        logic [7:0] len;
        logic [7:0] sum;
        logic [7:0] nb;
        int         n;
        int         cut;
        int         pick;

        // noise while hunting, sometimes closing a buffer
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n) begin
            nb = 8'($urandom_range(0, 255));
            if (nb == START_BYTE)
                nb = 8'h00;
            send_byte(nb, $urandom_range(0, 3) == 0, 1'b0, '0);
        end

        pick = $urandom_range(0, 19);
        if (pick == 0)
            len = 8'($urandom_range(100, 255));
        else if (pick < 4)
            len = 8'h00;
        else
            len = 8'($urandom_range(1, 12));

        addr = 8'($urandom_range(0, 255));
        frm.push_back(START_BYTE);
        frm.push_back(addr);
        frm.push_back(($urandom_range(0, 11) == 0) ? ~addr ^ 8'($urandom_range(1, 255))
                                                   : ~addr);
        frm.push_back(($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255))
                                                   : START_BYTE);
        frm.push_back(8'($urandom_range(0, 255)));
        frm.push_back(len);
        repeat (len) frm.push_back(8'($urandom_range(0, 255)));
        sum = 8'h00;
        foreach (frm[i]) sum = sum + frm[i];
        if ($urandom_range(0, 9) == 0)
            sum = sum + 8'($urandom_range(1, 255));
        frm.push_back(sum);
        frm.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : END_BYTE);

        if ($urandom_range(0, 7) == 0) begin
            // buffer ends before the end byte
            cut = $urandom_range(0, frm.size() - 2);
            for (int i = 0; i < cut; i++)
                send_byte(frm[i], 1'b0, 1'b0, '0);
            send_byte(frm[cut], 1'b1, 1'b0, '0);
        end else begin
            for (int i = 0; i < frm.size() - 1; i++)
                send_byte(frm[i], 1'b0, 1'b0, '0);
            if ($urandom_range(0, 1) == 0) begin
                send_byte(frm[frm.size() - 1], 1'b1, 1'b0, '0);
            end else begin
                send_byte(frm[frm.size() - 1], 1'b0, 1'b0, '0);
                repeat ($urandom_range(0, 3))
                    send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
                // now and then the buffer stays open and the next frame is skipped
                if ($urandom_range(0, 9) != 0)
                    send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
            end
        end
    endtask

    // result sink with random backpressure
    initial begin
        res_if.ready <= 1'b1;
        forever begin
            @(posedge clk);
            if (stall_en && $urandom_range(0, 4) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin : check_results
        t_result e;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (decoded_q.size() == 0) begin
                report($sformatf("unexpected result kind %0d status %0d",
                                 res_if.kind, res_if.status));
            end else begin
                e = decoded_q.pop_front();
                check_field("kind", 8'(res_if.kind), 8'(e.kind));
                check_field("payload_byte", res_if.payload_byte, e.payload_byte);
                check_field("payload_index", res_if.payload_index, e.payload_index);
                check_field("frame_address", res_if.frame_address, e.frame_address);
                check_field("frame_operation", res_if.frame_operation, e.frame_operation);
                check_field("frame_payload_length", res_if.frame_payload_length,
                            e.frame_payload_length);
                check_field("status", 8'(res_if.status), 8'(e.status));
            end
        end
    end

    initial begin : stimulus
        t_row directed[$];

        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_data         <= 8'h00;
        rx_if.valid      <= 1'b0;
        rx_if.rx_byte    <= 8'h00;
        rx_if.buffer_end <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        parse_phase = PH_HUNT;
        byte_pos    = 9'd0;
        frame_addr  = 8'h00;
        frame_op    = 8'h00;
        frame_len   = 8'h00;
        sum_acc     = 8'h00;
        hdr_good    = 1'b1;
        sum_good    = 1'b0;
        len_limit   = MAX_PAYLOAD_RST;

        set_limit(8'h00);

        // start byte that closes the buffer
        directed.push_back('{8'h68, 1'b1, 1'b1,
                             mk_res(KIND_STATUS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, ST_TRUNC)});
        // buffer end while hunting: nothing
        directed.push_back('{8'h5A, 1'b1, 1'b0, '0});
        // every check fails; checksum wins, payload still goes out
        directed.push_back('{8'h68, 1'b0, 1'b0, '0});
        directed.push_back('{8'hFF, 1'b0, 1'b0, '0});
        directed.push_back('{8'hFF, 1'b0, 1'b0, '0});
        directed.push_back('{8'h00, 1'b0, 1'b0, '0});
        directed.push_back('{8'h80, 1'b0, 1'b0, '0});
        directed.push_back('{8'h01, 1'b0, 1'b0, '0});
        directed.push_back('{8'h33, 1'b0, 1'b1,
                             mk_res(KIND_PAYLOAD, 8'h00, 8'h00, 8'hFF, 8'h80, 8'h01, ST_OK)});
        directed.push_back('{8'h00, 1'b0, 1'b0, '0});
        directed.push_back('{8'h00, 1'b0, 1'b1,
                             mk_res(KIND_STATUS, 8'h00, 8'h00, 8'hFF, 8'h80, 8'h01, ST_BAD_SUM)});
        // trailing byte of the buffer is ignored
        directed.push_back('{8'hFF, 1'b1, 1'b0, '0});
        // good header and sum, wrong end byte, empty payload
        directed.push_back('{8'h68, 1'b0, 1'b0, '0});
        directed.push_back('{8'h00, 1'b0, 1'b0, '0});
        directed.push_back('{8'hFF, 1'b0, 1'b0, '0});
        directed.push_back('{8'h68, 1'b0, 1'b0, '0});
        directed.push_back('{8'h7F, 1'b0, 1'b0, '0});
        directed.push_back('{8'h00, 1'b0, 1'b0, '0});
        directed.push_back('{8'h4E, 1'b0, 1'b0, '0});
        directed.push_back('{8'h17, 1'b1, 1'b1,
                             mk_res(KIND_STATUS, 8'h00, 8'h00, 8'h00, 8'h7F, 8'h00, ST_BAD_END)});
        // buffer cut right after the start byte
        directed.push_back('{8'h68, 1'b0, 1'b0, '0});
        directed.push_back('{8'h12, 1'b1, 1'b1,
                             mk_res(KIND_STATUS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, ST_TRUNC)});

        stall_en = 1'b1;
        foreach (directed[i])
            send_byte(directed[i].rx, directed[i].last, directed[i].typed, directed[i].exp);
        flush();

        for (int k = 0; k < PHASES; k++) begin
            case (k)
                0:       set_limit(8'hFF);
                1:       set_limit(8'($urandom_range(1, 254)));
                2:       set_limit(8'h03);
                default: set_limit(8'($urandom_range(0, 255)));
            endcase
            while (sent < directed.size() + (k + 1) * ITEMS / PHASES) begin
                stall_en = (k != PHASES - 1) && ($urandom_range(0, 2) != 0);
                send_frame();
            end
            flush();
        end

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
design/cfp_pkg.sv
design/cfp_in_if.sv
design/cfp_out_if.sv
design/cfp_parser.sv
design/cfp_out_stage.sv
design/checksum_frame_parser_core.sv
tb/tb.sv
